// File: hdl/pus_pkg.sv
// ----------------------------------------------------------------------------
// pus_pkg
// shared widths, defaults and register codes for the png scanline unfilter
// ----------------------------------------------------------------------------
package pus_pkg;

	// default sizes, handed to the top level parameters
	localparam int MAX_LINE_BYTES_DEF = 8192;
	localparam int MAX_BPP_DEF        = 8;

	// fixed field widths
	localparam int PIX_W     = 8;
	localparam int ROW_W     = 16;
	localparam int COLIDX_W  = 13;
	localparam int BPP_REG_W = 4;
	localparam int LB_REG_W  = 14;
	localparam int REM_W     = 3;   // remainder of a division by at most eight

	// stream packing
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 40;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = LB_REG_W;
	localparam logic [CFG_IDX_W-1:0] CFG_BPP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LB  = 1'b1;

	localparam logic [BPP_REG_W-1:0] BPP_RST = 4'd4;
	localparam logic [LB_REG_W-1:0]  LB_RST  = 14'd4;

	// status of the pixel slot recompute unit
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [REM_W-1:0] rem;
	} mod_status_t;

endpackage

// File: hdl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// png filter reconstruction (none, sub, up, average, paeth), one byte a cycle
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: data_byte; tuser: image_start
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: pixel_byte, row_index,
//                                              column_index; tlast: end_of_row;
//                                              tuser: bad_filter
//  cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
//  one byte per cycle sustained while neither m_axis nor a slot recompute
//  stalls; a data byte reaches m_axis through the rebuild stage register and
//  then the output register, with the line store read in the accept cycle
//  a filter type byte updates the row state only and gives no output
//  writing bytes_per_pixel recomputes the pixel slot of the current column
//  bit-serially: input stalls until the new slot is loaded
//  asynchronous reset clears control and the neighbor histories; the line
//  store is not cleared and holds garbage until a row has written it
//  m_axis stall holds the output register; input keeps flowing while the
//  rebuild stage can move into a free or draining output register
// ----------------------------------------------------------------------------
module png_scanline_unfilter
	import pus_pkg::*;
#(
	parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
	parameter int MAX_BPP        = MAX_BPP_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic                  s_axis_tuser,   // [0] image_start

	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] pixel_byte, [23:8] row_index,
	                                              // [36:24] column_index, [39:37] zero
	output logic                  m_axis_tlast,   // end_of_row
	output logic                  m_axis_tuser,   // [0] bad_filter

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int COL_W  = $clog2(MAX_LINE_BYTES);
	localparam int SLOT_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
	// width that holds a clamped line length and a column plus one
	localparam int LBC_W  = (COL_W + 1 > LB_REG_W) ? COL_W + 1 : LB_REG_W;

	typedef enum logic [2:0] {
		FILT_NONE,
		FILT_SUB,
		FILT_UP,
		FILT_AVG,
		FILT_PAETH,
		FILT_BAD
	} filt_t;

	// configuration
	logic [BPP_REG_W-1:0] bpp_q;
	logic [LB_REG_W-1:0]  lb_q;
	logic [BPP_REG_W-1:0] bpp_eff;
	logic [LBC_W-1:0]     lb_eff;
	logic                 cfg_wr;
	logic                 bpp_wr;

	// row state
	logic [COL_W-1:0]  col_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ROW_W-1:0]  row_q;
	filt_t             filter_q;
	logic              awaiting_q;

	// accept stage decode
	logic              in_acc;
	logic              aw_eff;
	logic              data_acc;
	logic [ROW_W-1:0]  row_eff;
	logic              last_s0;
	logic              a_en_s0;
	logic [BPP_REG_W-1:0] slot_inc;
	logic [PIX_W-1:0]  byte_in;

	// rebuild stage
	logic              s1_valid_q;
	logic [PIX_W-1:0]  x_s1;
	logic [COL_W-1:0]  col_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              last_s1;
	logic              a_en_s1;
	filt_t             filter_s1;
	logic              s1_adv;
	logic              s1_free;
	logic              s1_fire;

	// neighbor histories, one byte per pixel slot
	logic [PIX_W-1:0] left_q   [MAX_BPP];
	logic [PIX_W-1:0] upleft_q [MAX_BPP];

	// output register
	logic              out_valid_q;
	logic [PIX_W-1:0]  pix_q;
	logic [ROW_W-1:0]  row_out_q;
	logic [COL_W-1:0]  col_out_q;
	logic              last_q;
	logic              bad_q;

	logic [PIX_W-1:0]  up_rd;
	logic [PIX_W-1:0]  nb_a;
	logic [PIX_W-1:0]  nb_b;
	logic [PIX_W-1:0]  nb_c;
	logic [PIX_W-1:0]  pred;
	logic [PIX_W-1:0]  result;
	logic              bad;
	logic [PIX_W:0]    avg_sum;
	logic signed [PIX_W+2:0] pa;
	logic signed [PIX_W+2:0] pb;
	logic signed [PIX_W+2:0] pc;
	logic [PIX_W+2:0]  pa_abs;
	logic [PIX_W+2:0]  pb_abs;
	logic [PIX_W+2:0]  pc_abs;

	mod_status_t mod_st;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign bpp_wr    = cfg_wr && (cfg_index == CFG_BPP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= BPP_RST;
			lb_q  <= LB_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_BPP: bpp_q <= cfg_data[BPP_REG_W-1:0];
				CFG_LB:  lb_q  <= cfg_data[LB_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// out-of-range settings clamp to the legal range
	always_comb begin
		if (bpp_q == '0) begin
			bpp_eff = BPP_REG_W'(1);
		end else if (bpp_q > BPP_REG_W'(MAX_BPP)) begin
			bpp_eff = BPP_REG_W'(MAX_BPP);
		end else begin
			bpp_eff = bpp_q;
		end
		if (lb_q == '0) begin
			lb_eff = LBC_W'(1);
		end else if (LBC_W'(lb_q) > LBC_W'(MAX_LINE_BYTES)) begin
			lb_eff = LBC_W'(MAX_LINE_BYTES);
		end else begin
			lb_eff = LBC_W'(lb_q);
		end
	end

	// slot of the current column is rebuilt after a pixel size change
	pus_slot_mod #(
		.DIV_W (COL_W)
	) u_slot_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (bpp_wr),
		.dividend (col_q),
		.divisor  (bpp_eff),
		.status   (mod_st)
	);

	// ---------------- accept stage ----------------
	assign s1_adv        = !out_valid_q || m_axis_tready;
	assign s1_free       = !s1_valid_q || s1_adv;
	assign s_axis_tready = s1_free && !mod_st.busy && !bpp_wr;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign byte_in       = s_axis_tdata[PIX_W-1:0];

	// image start forces a fresh filter type byte on row 0
	assign aw_eff   = s_axis_tuser || awaiting_q;
	assign row_eff  = s_axis_tuser ? '0 : row_q;
	assign data_acc = in_acc && !aw_eff;
	assign last_s0  = (LBC_W'(col_q) + LBC_W'(1)) >= lb_eff;
	assign a_en_s0  = LBC_W'(col_q) >= LBC_W'(bpp_eff);
	assign slot_inc = BPP_REG_W'(slot_q) + BPP_REG_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			slot_q     <= '0;
			row_q      <= '0;
			filter_q   <= FILT_NONE;
			awaiting_q <= 1'b1;
		end else if (in_acc) begin
			if (aw_eff) begin
				// filter type byte opens the row
				filter_q   <= (byte_in > PIX_W'(FILT_PAETH)) ? FILT_BAD
				                                             : filt_t'(byte_in[2:0]);
				awaiting_q <= 1'b0;
				col_q      <= '0;
				slot_q     <= '0;
				row_q      <= row_eff;
			end else if (last_s0) begin
				col_q      <= '0;
				slot_q     <= '0;
				awaiting_q <= 1'b1;
				if (row_q != '1) begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q  <= col_q + COL_W'(1);
				slot_q <= (slot_inc == bpp_eff) ? '0 : SLOT_W'(slot_inc);
			end
		end else if (mod_st.done) begin
			slot_q <= SLOT_W'(mod_st.rem);
		end
	end

	// previous row store: read in the accept cycle, written after rebuild
	pus_line_ram #(
		.DEPTH (MAX_LINE_BYTES),
		.AW    (COL_W)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (col_s1),
		.wdata (result),
		.re    (data_acc),
		.raddr (col_q),
		.rdata (up_rd)
	);

	// ---------------- rebuild stage ----------------
	assign s1_fire = s1_valid_q && s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (data_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_acc) begin
			x_s1      <= byte_in;
			col_s1    <= col_q;
			slot_s1   <= slot_q;
			row_s1    <= row_q;
			last_s1   <= last_s0;
			a_en_s1   <= a_en_s0;
			filter_s1 <= filter_q;
		end
	end

	// neighbors: a and c vanish in the first pixel, b and c on row 0
	assign nb_a = a_en_s1 ? left_q[slot_s1] : '0;
	assign nb_b = (row_s1 == '0) ? '0 : up_rd;
	assign nb_c = (a_en_s1 && (row_s1 != '0)) ? upleft_q[slot_s1] : '0;

	assign avg_sum = {1'b0, nb_a} + {1'b0, nb_b};

	// paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
	always_comb begin
		pa = $signed({3'b000, nb_b}) - $signed({3'b000, nb_c});
		pb = $signed({3'b000, nb_a}) - $signed({3'b000, nb_c});
		pc = pa + pb;
		pa_abs = (pa < 0) ? (PIX_W + 3)'(-pa) : (PIX_W + 3)'(pa);
		pb_abs = (pb < 0) ? (PIX_W + 3)'(-pb) : (PIX_W + 3)'(pb);
		pc_abs = (pc < 0) ? (PIX_W + 3)'(-pc) : (PIX_W + 3)'(pc);
	end

	always_comb begin
		bad = 1'b0;
		case (filter_s1)
			FILT_NONE:  pred = '0;
			FILT_SUB:   pred = nb_a;
			FILT_UP:    pred = nb_b;
			FILT_AVG:   pred = avg_sum[PIX_W:1];
			FILT_PAETH: begin
				if ((pa_abs <= pb_abs) && (pa_abs <= pc_abs)) begin
					pred = nb_a;
				end else if (pb_abs <= pc_abs) begin
					pred = nb_b;
				end else begin
					pred = nb_c;
				end
			end
			default: begin
				// unknown filter type: byte goes out raw
				pred = '0;
				bad  = 1'b1;
			end
		endcase
	end

	assign result = x_s1 + pred;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BPP; i++) begin
				left_q[i]   <= '0;
				upleft_q[i] <= '0;
			end
		end else if (s1_fire) begin
			left_q[slot_s1]   <= result;
			upleft_q[slot_s1] <= nb_b;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			pix_q     <= result;
			row_out_q <= row_s1;
			col_out_q <= col_s1;
			last_q    <= last_s1;
			bad_q     <= bad;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - PIX_W - ROW_W - COLIDX_W)'(0),
	                        COLIDX_W'(col_out_q), row_out_q, pix_q};
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = bad_q;

`ifndef SYNTHESIS
	// no request slips in while the pixel slot is being rebuilt
	a_no_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !mod_st.busy)
		else $error("request accepted during slot recompute");

	// slot always within the current pixel size once settled
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		!mod_st.busy |-> (BPP_REG_W'(slot_q) < bpp_eff))
		else $error("pixel slot out of range");

	// a filter type byte never enters the rebuild stage
	a_filter_no_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && aw_eff) |=> !s1_valid_q)
		else $error("filter type byte produced a result");

	// the last byte of a row arms the next filter type byte
	a_last_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(data_acc && last_s0) |=> awaiting_q)
		else $error("row end did not await a filter type byte");
`endif

endmodule

// File: hdl/pus_line_ram.sv
// ----------------------------------------------------------------------------
// pus_line_ram
// previous row store, one write and one registered read port
// ----------------------------------------------------------------------------
module pus_line_ram
	import pus_pkg::*;
#(
	parameter int DEPTH = MAX_LINE_BYTES_DEF,
	parameter int AW    = $clog2(MAX_LINE_BYTES_DEF)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [PIX_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/pus_slot_mod.sv
// ----------------------------------------------------------------------------
// pus_slot_mod
// bit-serial remainder of the column by the pixel size, one bit per cycle
// ----------------------------------------------------------------------------
module pus_slot_mod
	import pus_pkg::*;
#(
	parameter int DIV_W = $clog2(MAX_LINE_BYTES_DEF)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_W-1:0]     dividend,
	input  logic [BPP_REG_W-1:0] divisor,
	output mod_status_t          status
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] shift_q;
	logic [REM_W-1:0] rem_q;
	logic             done_q;
	logic [REM_W:0]   trial;
	logic [REM_W:0]   dvs;

	assign trial = {rem_q, shift_q[DIV_W-1]};
	assign dvs   = (REM_W + 1)'(divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DIV_W);
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (cnt_q != '0) begin
			shift_q <= {shift_q[DIV_W-2:0], 1'b0};
			if (trial >= dvs) begin
				rem_q <= REM_W'(trial - dvs);
			end else begin
				rem_q <= REM_W'(trial);
			end
		end
	end

	assign status.busy = (cnt_q != '0) || done_q;
	assign status.done = done_q;
	assign status.rem  = rem_q;

endmodule
